// ===== rtl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// types and character constants shared by the base64 stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

	// one character transfer on the input side
	typedef struct packed {
		logic [7:0] char_code;
		logic       start_string;
	} in_t;

	// one result transfer on the output side
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       decode_error;
		logic       halted;
	} out_t;

	// character classes
	typedef enum logic [1:0] {
		CLS_SEXTET = 2'd0,
		CLS_SPACE  = 2'd1,
		CLS_PAD    = 2'd2,
		CLS_BAD    = 2'd3
	} char_class_t;

	// phase within a group of four sextets
	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;
	localparam logic [1:0] PHASE_FOURTH = 2'd3;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam logic [7:0] LOWER_BASE = 8'd26;
	localparam logic [7:0] DIGIT_BASE = 8'd52;
	localparam logic [5:0] VAL_62     = 6'd62;
	localparam logic [5:0] VAL_63     = 6'd63;

endpackage

// ===== rtl/b64sd_classify.sv =====
// ----------------------------------------------------------------------------
// b64sd_classify
// maps one raw character to its class and six-bit value
// ----------------------------------------------------------------------------
module b64sd_classify (
	input  logic [7:0]           char_code,
	output b64sd_pkg::char_class_t char_class,
	output logic [5:0]           sextet
);

	logic [7:0] diff;

	always_comb begin
		char_class = b64sd_pkg::CLS_SEXTET;
		diff       = 8'd0;
		priority if (char_code >= b64sd_pkg::CH_UPPER_A && char_code <= b64sd_pkg::CH_UPPER_Z) begin
			diff = char_code - b64sd_pkg::CH_UPPER_A;
		end else if (char_code >= b64sd_pkg::CH_LOWER_A
				&& char_code <= b64sd_pkg::CH_LOWER_Z) begin
			diff = char_code - b64sd_pkg::CH_LOWER_A + b64sd_pkg::LOWER_BASE;
		end else if (char_code >= b64sd_pkg::CH_DIGIT_0
				&& char_code <= b64sd_pkg::CH_DIGIT_9) begin
			diff = char_code - b64sd_pkg::CH_DIGIT_0 + b64sd_pkg::DIGIT_BASE;
		end else if (char_code == b64sd_pkg::CH_PLUS || char_code == b64sd_pkg::CH_MINUS) begin
			diff = {2'b00, b64sd_pkg::VAL_62};
		end else if (char_code == b64sd_pkg::CH_SLASH || char_code == b64sd_pkg::CH_UNDER) begin
			diff = {2'b00, b64sd_pkg::VAL_63};
		end else if (char_code == b64sd_pkg::CH_EQUALS) begin
			char_class = b64sd_pkg::CLS_PAD;
		end else if (char_code == b64sd_pkg::CH_SPACE
				|| (char_code >= b64sd_pkg::CH_TAB && char_code <= b64sd_pkg::CH_CR)) begin
			char_class = b64sd_pkg::CLS_SPACE;
		end else begin
			char_class = b64sd_pkg::CLS_BAD;
		end
	end

	assign sextet = diff[5:0];

endmodule

// ===== rtl/b64sd_state.sv =====
// ----------------------------------------------------------------------------
// b64sd_state
// decoder state and per-character result logic
// ----------------------------------------------------------------------------
module b64sd_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  b64sd_pkg::in_t   item,
	output b64sd_pkg::out_t  result
);

	logic [11:0] acc_q;
	logic [1:0]  phase_q;
	logic        halt_q;
	logic        err_q;

	logic [11:0] acc_base, acc_next;
	logic [1:0]  phase_base, phase_next;
	logic        halt_base, halt_next;
	logic        err_base, err_next;
	logic [7:0]  byte_val;
	logic        byte_vld;

	b64sd_pkg::char_class_t char_class;
	logic [5:0]             sextet;

	b64sd_classify u_classify (
		.char_code  (item.char_code),
		.char_class (char_class),
		.sextet     (sextet)
	);

	always_comb begin
		// start of string clears everything before the character is handled
		acc_base   = item.start_string ? 12'd0 : acc_q;
		phase_base = item.start_string ? 2'd0  : phase_q;
		halt_base  = item.start_string ? 1'b0  : halt_q;
		err_base   = item.start_string ? 1'b0  : err_q;

		acc_next   = acc_base;
		phase_next = phase_base;
		halt_next  = halt_base;
		err_next   = err_base;
		byte_val   = 8'd0;
		byte_vld   = 1'b0;

		if (!halt_base && !err_base) begin
			unique case (char_class)
				b64sd_pkg::CLS_SEXTET: begin
					acc_next   = {acc_base[5:0], sextet};
					phase_next = phase_base + 2'd1;
					unique case (phase_base)
						b64sd_pkg::PHASE_FIRST: begin
							byte_vld = 1'b0;
						end
						b64sd_pkg::PHASE_SECOND: begin
							byte_val = acc_next[11:4];
							byte_vld = 1'b1;
						end
						b64sd_pkg::PHASE_THIRD: begin
							byte_val = acc_next[9:2];
							byte_vld = 1'b1;
						end
						b64sd_pkg::PHASE_FOURTH: begin
							byte_val = acc_next[7:0];
							byte_vld = 1'b1;
						end
						default: begin
							byte_vld = 1'b0;
						end
					endcase
				end
				b64sd_pkg::CLS_SPACE: begin
					byte_vld = 1'b0;
				end
				b64sd_pkg::CLS_PAD: begin
					halt_next = 1'b1;
				end
				b64sd_pkg::CLS_BAD: begin
					err_next = 1'b1;
				end
				default: begin
					byte_vld = 1'b0;
				end
			endcase
		end

		result.out_byte     = byte_val;
		result.byte_valid   = byte_vld;
		result.decode_error = err_next;
		result.halted       = halt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 12'd0;
			phase_q <= 2'd0;
			halt_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (advance) begin
			acc_q   <= acc_next;
			phase_q <= phase_next;
			halt_q  <= halt_next;
			err_q   <= err_next;
		end
	end

endmodule

// ===== rtl/base64_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// base64 text decoder, one character in and one result out per transfer
// ----------------------------------------------------------------------------
//
//   channel   signals                               direction  payload
//   char      char_valid / char_ready / char_item   in         b64sd_pkg::in_t
//   res       res_valid  / res_ready  / res_item    out        b64sd_pkg::out_t
//
// every character transfer gives exactly one result transfer, through the input
// stage and then the result stage; one character per cycle is sustained while res_ready is high
// arst_n clears the accumulator, phase, halt and error flags and both stages
// a stalled result holds in the output stage; the input stage keeps taking
// characters until both stages are full, so no bubble is lost on a stall
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_ready,
	input  b64sd_pkg::in_t  char_item,
	output logic            res_valid,
	input  logic            res_ready,
	output b64sd_pkg::out_t res_item
);

	// input stage
	logic           valid_s1;
	b64sd_pkg::in_t item_s1;

	// result stage
	logic            valid_s2;
	b64sd_pkg::out_t res_s2;

	// combinational result of the character in the input stage
	b64sd_pkg::out_t res_comb;

	logic advance;
	logic res_free;

	// result stage can take a new value when empty or being drained
	assign res_free   = !valid_s2 || res_ready;
	// character in stage one moves on and commits its state update
	assign advance    = valid_s1 && res_free;
	// stage one is free when empty or moving on this cycle
	assign char_ready = !valid_s1 || res_free;

	b64sd_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (res_comb)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = valid_s2;
	assign res_item  = res_s2;

endmodule

// ===== sim/base64_decode_checker.sv =====
// ----------------------------------------------------------------------------
// base64_decode_checker
// watches both channels of the decoder, predicts every result and compares
// ----------------------------------------------------------------------------
module base64_decode_checker
	import b64sd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	input  logic char_ready,
	input  in_t  char_item,
	input  logic res_valid,
	input  logic res_ready,
	input  out_t res_item,
	output int   fail_count,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [11:0] acc_bits  = '0;
	logic [1:0]  group_pos = PHASE_FIRST;
	logic        pad_seen  = 1'b0;
	logic        bad_seen  = 1'b0;
	out_t        expected_results[$];
	int          mismatches = 0;
	int          waiting    = 0;

	assign fail_count    = mismatches;
	assign pending_count = waiting;

	function automatic char_class_t classify(input logic [7:0] c, output logic [5:0] v);
		v = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			v = 6'(c - CH_UPPER_A);
			return CLS_SEXTET;
		end
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			v = 6'(c - CH_LOWER_A + LOWER_BASE);
			return CLS_SEXTET;
		end
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			v = 6'(c - CH_DIGIT_0 + DIGIT_BASE);
			return CLS_SEXTET;
		end
		if (c == CH_PLUS || c == CH_MINUS) begin
			v = VAL_62;
			return CLS_SEXTET;
		end
		if (c == CH_SLASH || c == CH_UNDER) begin
			v = VAL_63;
			return CLS_SEXTET;
		end
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			return CLS_SPACE;
		if (c == CH_EQUALS)
			return CLS_PAD;
		return CLS_BAD;
	endfunction

	// advances the decoder state by one character and returns its result
	function automatic out_t decode_char(input in_t item);
		out_t        res;
		logic [5:0]  v;
		char_class_t cls;
		if (item.start_string) begin
			acc_bits  = '0;
			group_pos = PHASE_FIRST;
			pad_seen  = 1'b0;
			bad_seen  = 1'b0;
		end
		res = '0;
		cls = classify(item.char_code, v);
		if (!pad_seen && !bad_seen) begin
			case (cls)
				CLS_PAD: pad_seen = 1'b1;
				CLS_BAD: bad_seen = 1'b1;
				CLS_SEXTET: begin
					acc_bits = {acc_bits[5:0], v};
					res.byte_valid = 1'b1;
					case (group_pos)
						PHASE_SECOND: res.out_byte = acc_bits[11:4];
						PHASE_THIRD:  res.out_byte = acc_bits[9:2];
						PHASE_FOURTH: res.out_byte = acc_bits[7:0];
						default:      res.byte_valid = 1'b0;
					endcase
					group_pos = group_pos + 2'd1;
				end
				default: ;
			endcase
		end
		res.decode_error = bad_seen;
		res.halted       = pad_seen;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			acc_bits  = '0;
			group_pos = PHASE_FIRST;
			pad_seen  = 1'b0;
			bad_seen  = 1'b0;
			expected_results.delete();
			waiting = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: %p", res_item);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_byte", want.out_byte, res_item.out_byte);
					check_field("byte_valid", 8'(want.byte_valid), 8'(res_item.byte_valid));
					check_field("decode_error", 8'(want.decode_error),
						8'(res_item.decode_error));
					check_field("halted", 8'(want.halted), 8'(res_item.halted));
				end
			end
			if (char_valid && char_ready)
				expected_results.insert(expected_results.size(), decode_char(char_item));
			waiting = expected_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives base64 text into the decoder in bursts while the result side stalls
// on changing patterns; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module testbench;
	import b64sd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1150;

	// what kind of character to draw
	typedef enum logic [1:0] {
		PICK_SEXTET,
		PICK_SPACE,
		PICK_BAD,
		PICK_ANY
	} pick_t;

	logic clk;
	logic arst_n;
	logic char_valid;
	logic char_ready;
	in_t  char_item;
	logic res_valid;
	logic res_ready;
	out_t res_item;
	int   fail_count;
	int   pending_count;

	int burst_left = 0;
	int items_sent = 0;

	base64_stream_decoder_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	base64_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.char_item     (char_item),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_item      (res_item),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// draws one character of the requested kind
	function automatic logic [7:0] pick_char(input pick_t kind);
		int v;
		case (kind)
			PICK_SEXTET: begin
				v = $urandom_range(0, 63);
				// both spellings of values 62 and 63 show up
				if (v < 26)
					return CH_UPPER_A + 8'(v);
				else if (v < 52)
					return CH_LOWER_A + 8'(v - 26);
				else if (v < 62)
					return CH_DIGIT_0 + 8'(v - 52);
				else if (v == 62)
					return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
				else
					return $urandom_range(0, 1) ? CH_UNDER : CH_SLASH;
			end
			PICK_SPACE: begin
				v = $urandom_range(0, 5);
				// space itself or one of tab .. carriage return
				return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
			end
			PICK_BAD: begin
				// ranges that hold no alphabet, whitespace or padding character
				case ($urandom_range(0, 5))
					0:       return 8'($urandom_range(8'h00, 8'h08));
					1:       return 8'($urandom_range(8'h0E, 8'h1F));
					2:       return 8'($urandom_range(8'h21, 8'h2A));
					3:       return 8'($urandom_range(8'h3E, 8'h40));
					4:       return 8'($urandom_range(8'h80, 8'hFF));
					default: return 8'($urandom_range(8'h7B, 8'hFF));
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one character transfer; called and returns at a falling edge
	task automatic send_char(input logic [7:0] ch, input logic start);
		in_t item;
		int  gap;
		item.char_code    = ch;
		item.start_string = start;
		char_item  <= item;
		char_valid <= 1'b1;
		do
			@(posedge clk);
		while (!char_ready);
		@(negedge clk);
		items_sent++;
		// sender works in bursts, some of them back to back with no gap
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == 0);
	endtask

	// receiver: full speed, a rotating stall pattern, or random stalls
	initial begin
		int          mode;
		int          span;
		int          duty;
		logic [15:0] pattern;
		res_ready = 1'b0;
		forever begin
			mode    = $urandom_range(0, 2);
			span    = $urandom_range(16, 96);
			duty    = $urandom_range(1, 3);
			pattern = 16'($urandom) | 16'h0001;
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0:       res_ready <= 1'b1;
					1:       res_ready <= pattern[k % 16];
					default: res_ready <= ($urandom_range(0, 3) < duty);
				endcase
			end
		end
	end

	// run limit far beyond the slowest legal run
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int  len;
		int  bad_at;
		int  kind;
		bit  first;
		bit  start_first;
		char_valid = 1'b0;
		char_item  = '0;
		arst_n     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a full group, all four values 62/63 spellings
		send_text("TWFu");
		send_text("/_+-");
		// every whitespace character skipped inside a group
		send_char(CH_UPPER_A, 1'b1);
		send_char(CH_SPACE, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(CH_LOWER_Z, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(CH_DIGIT_9, 1'b0);
		send_char(8'h0B, 1'b0);
		send_char(8'h0C, 1'b0);
		send_char(8'h0A, 1'b0);
		// padding halts, later alphabet and invalid characters ignored
		send_char(CH_EQUALS, 1'b0);
		send_char(8'h51, 1'b0);
		send_char(8'h21, 1'b0);
		// invalid at the top of the byte range, then ignored until a new string
		send_char(8'hFF, 1'b1);
		send_char(CH_UPPER_A, 1'b0);
		send_char(CH_EQUALS, 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'h80, 1'b1);

		// random part, mostly well-formed strings with random content
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 16);
				// broken strings carry one invalid character somewhere
				bad_at      = (kind >= 70) ? $urandom_range(0, len - 1) : -1;
				start_first = ($urandom_range(0, 9) != 0);
				first       = 1'b1;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_char(pick_char(PICK_SPACE), first && start_first);
						first = 1'b0;
					end
					if (i == bad_at)
						send_char(pick_char(PICK_BAD), first && start_first);
					else
						send_char(pick_char(PICK_SEXTET), first && start_first);
					first = 1'b0;
				end
				// padding, then trailing characters that are ignored
				if ($urandom_range(0, 1)) begin
					send_char(CH_EQUALS, 1'b0);
					if ($urandom_range(0, 1))
						send_char(CH_EQUALS, 1'b0);
					if ($urandom_range(0, 2) == 0)
						repeat ($urandom_range(1, 4))
							send_char(pick_char(PICK_ANY), 1'b0);
				end
			end else begin
				// noise: raw bytes with the start bit set now and then
				repeat ($urandom_range(1, 8))
					send_char(pick_char(PICK_ANY), $urandom_range(0, 3) == 0);
			end
		end
		char_valid <= 1'b0;

		// drain every outstanding result, then allow stray transfers to show
		while (pending_count != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/b64sd_pkg.sv
rtl/b64sd_classify.sv
rtl/b64sd_state.sv
rtl/base64_stream_decoder_top.sv
sim/base64_decode_checker.sv
sim/testbench.sv
